/* src/isq_pkg.sv */
// Package for the indexed sequence store: command and status codes,
// the transaction payload structs and the per-cell control struct.
// No dependencies.
package isq_pkg;

  // Command codes carried in the input transaction.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_PEEK   = 2'd3;

  // Status codes carried in the result transaction.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // Fixed field widths of the transactions.
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [1:0]          command;
    logic [POS_W-1:0]    position;
    logic signed [31:0]  item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  read_value;
    logic                found;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  // Operation enables broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
    logic srch_en;
    logic peek_en;
  } isq_ctl_t;

endpackage

/* src/isq_cell.sv */
// One storage cell of the sequence chain: holds one entry, shifts with its
// neighbors on insert and remove, and registers its local search and peek result.
// Depends on isq_pkg.
module isq_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CW         = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  isq_pkg::isq_ctl_t      ctl,
  input  logic [CW-1:0]          pos,
  input  logic [CW-1:0]          cnt,
  input  logic [DATA_WIDTH-1:0]  val,
  input  logic [DATA_WIDTH-1:0]  left_data,
  input  logic [DATA_WIDTH-1:0]  right_data,
  output logic [DATA_WIDTH-1:0]  data,
  output logic                   hit,
  output logic [31:0]            rd
);
  import isq_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic [31:0]           rd_r, rd_nxt;

  // Entry update: insert moves later entries back, remove pulls them forward.
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en) begin
      if (MY_IDX == pos) begin
        data_nxt = val;
      end else if (MY_IDX > pos) begin
        data_nxt = left_data;
      end
    end else if (ctl.rem_en) begin
      if (MY_IDX >= pos) begin
        data_nxt = right_data;
      end
    end
  end

  // Local lookup results; zero unless this cell answers the operation.
  always_comb begin
    hit_nxt = ctl.srch_en && (MY_IDX < cnt) && (data_r == val);
    rd_nxt  = '0;
    if (ctl.peek_en && (MY_IDX == pos)) begin
      rd_nxt = 32'(signed'(data_r));
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;
  assign rd   = rd_r;

endmodule

/* src/indexed_sequence_store_top.sv */
// Indexed sequence store: an ordered list of up to DEPTH signed entries kept
// in a chain of cells. At the edge that accepts a transaction (start high
// while busy is low) every cell shifts, compares and reads in parallel, and
// during the following cycle, while busy is high, the per-cell results are
// merged into one result. The result is on out_item for exactly one cycle
// with out_valid high; the receiver cannot hold it off, so it must take it in
// that cycle. A new transaction may be accepted in the cycle the result is
// shown, but not while busy is high.
// Depends on isq_pkg and isq_cell.
module indexed_sequence_store_top #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  isq_pkg::in_item_t   in_item,
  output logic                out_valid,
  output isq_pkg::out_item_t  out_item
);
  import isq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic                  accept;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  busy_r;
  logic [1:0]            status_r, status_nxt;
  logic                  out_valid_r;
  out_item_t             out_item_r, out_item_nxt;
  isq_ctl_t              ctl;
  logic [CW-1:0]         pos;
  logic [DATA_WIDTH-1:0] sval;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [31:0]           cell_rd   [DEPTH];
  logic [DEPTH-1:0]      cell_hit;
  logic [31:0]           rd_merge;

  assign accept = start && !busy_r;
  assign pos    = CW'(in_item.position);
  assign sval   = DATA_WIDTH'(in_item.item_value);

  // Status check and count update for the incoming transaction.
  always_comb begin
    status_nxt  = ST_OK;
    count_nxt   = count_r;
    ctl         = '0;
    if (accept) begin
      unique case (in_item.command)
        CMD_INSERT: begin
          if (pos > count_r) begin
            status_nxt = ST_RANGE;
          end else if (count_r >= DEPTH_C) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.ins_en = 1'b1;
            count_nxt  = count_r + CW'(1);
          end
        end
        CMD_REMOVE, CMD_PEEK: begin
          if (count_r == '0) begin
            status_nxt = (pos == '0) ? ST_EMPTY : ST_RANGE;
          end else if (pos >= count_r) begin
            status_nxt = ST_RANGE;
          end else if (in_item.command == CMD_REMOVE) begin
            ctl.rem_en = 1'b1;
            count_nxt  = count_r - CW'(1);
          end else begin
            ctl.peek_en = 1'b1;
          end
        end
        CMD_SEARCH: begin
          ctl.srch_en = 1'b1;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // The chain of storage cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = sval;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    isq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .pos        (pos),
      .cnt        (count_r),
      .val        (sval),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit        (cell_hit[i]),
      .rd         (cell_rd[i])
    );
  end

  // Merge the registered per-cell results; at most one cell reads nonzero.
  always_comb begin
    rd_merge = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_merge = rd_merge | cell_rd[k];
    end
  end

  always_comb begin
    out_item_nxt.read_value  = rd_merge;
    out_item_nxt.found       = |cell_hit;
    out_item_nxt.status      = status_r;
    out_item_nxt.entry_count = COUNT_W'(count_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= accept;
      out_valid_r <= busy_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (busy_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result appears only in the cycle after a busy cycle.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result strobe without a preceding busy cycle");

  // Every accepted transaction leads to exactly one result, which follows its busy cycle.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("accepted transaction produced no result");

  // Busy lasts a single cycle.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("busy held longer than one cycle");

  // The entry count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count beyond capacity");

  // A full status is only reported when the list is at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_FULL) |-> (count_r == DEPTH_C))
    else $error("full status with room left");

endmodule
